// ----- sv/dso_pkg.sv -----
// Shared types and constants for the depth scan-line obstacle detector.
// No dependencies; compiled first.
package dso_pkg;

   // field widths fixed by the pixel and register formats
   localparam int DEPTH_W   = 16;
   localparam int MIN_RUN_W = 11;
   localparam int COUNT_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_OBSTACLE_DISTANCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_THRESHOLD    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RUN_LENGTH    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_LIMIT       = 2'd3;

   // register reset values
   localparam logic [DEPTH_W-1:0]   OBSTACLE_DISTANCE_RST = 16'd1000;
   localparam logic [DEPTH_W-1:0]   JUMP_THRESHOLD_RST    = 16'd70;
   localparam logic [MIN_RUN_W-1:0] MIN_RUN_LENGTH_RST    = 11'd7;
   localparam logic [COUNT_W-1:0]   FRAME_LIMIT_RST       = 16'd10;

   // saturation value of the marked frame counter
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // run segmentation settings
   typedef struct packed {
      logic [DEPTH_W-1:0]   obstacle_distance;
      logic [DEPTH_W-1:0]   jump_threshold;
      logic [MIN_RUN_W-1:0] min_run_length;
   } seg_cfg_type;

   // end of row report from the run segmenter to the frame counter
   typedef struct packed {
      logic valid;
      logic hit;
   } row_done_type;

endpackage

// ----- sv/dso_req_if.sv -----
// Request channel of the obstacle detector: one depth pixel per request.
// Depends on dso_pkg for the pixel width.
interface dso_req_if;
   import dso_pkg::*;

   logic               valid;
   logic               ready;
   logic [DEPTH_W-1:0] depth_sample;
   logic               row_end;

   modport source (output valid, depth_sample, row_end, input ready);
   modport sink   (input valid, depth_sample, row_end, output ready);
endinterface

// ----- sv/dso_rsp_if.sv -----
// Response channel of the obstacle detector: one frame verdict per row.
// Depends on dso_pkg for the counter width.
interface dso_rsp_if;
   import dso_pkg::*;

   logic               valid;
   logic               ready;
   logic               obstacle_alarm;
   logic               frame_marked;
   logic [COUNT_W-1:0] consecutive_frames;

   modport source (output valid, obstacle_alarm, frame_marked, consecutive_frames,
                   input ready);
   modport sink   (input valid, obstacle_alarm, frame_marked, consecutive_frames,
                   output ready);
endinterface

// ----- sv/depth_scanline_obstacle_detector.sv -----
// Top level of the depth scan-line obstacle detector.
// Depends on dso_pkg, dso_req_if, dso_rsp_if, dso_run_seg and dso_frame_out.
//
// Usage:
//   req carries one depth pixel (mm, zero = invalid) per request, with row_end
//   set on the last pixel of the scan row. Pixels close to each other form runs;
//   a run longer than min_run_length whose mean depth is below the obstacle
//   distance marks the frame.
//   rsp carries one response per row, taken from the request with row_end set:
//   frame marked, saturating count of consecutive marked frames and the alarm.
//   csr writes a register (index 0..3) when csr_write_enable is high; write only
//   while no request or response is in flight.
// Throughput and registers:
//   one request per cycle sustained while no row-end request waits for the
//   response slot; a request is registered at the input and evaluated from
//   there, and the response is registered in dso_frame_out. Each pixel takes one
//   pass through a 16-bit by length multiplier and a compare.
// Reset: synchronous; clears run state, frame counter and valid bits, loads defaults.
// Stall: a pending response holds; the input register keeps taking pixels
//   without row_end, and a row-end request waits until the response is taken.
module depth_scanline_obstacle_detector #(
   parameter int MAX_ROW_PIXELS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   dso_req_if.sink                             req,
   dso_rsp_if.source                           rsp,
   input  logic                                csr_write_enable,
   input  logic [dso_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dso_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import dso_pkg::*;

   logic [DEPTH_W-1:0]   obstacle_distance_ff;
   logic [DEPTH_W-1:0]   jump_threshold_ff;
   logic [MIN_RUN_W-1:0] min_run_length_ff;
   logic [COUNT_W-1:0]   frame_count_limit_ff;

   logic                 in_valid_ff;
   logic [DEPTH_W-1:0]   in_depth_ff;
   logic                 in_row_end_ff;

   logic                 advance;
   logic                 can_take;
   seg_cfg_type          seg_cfg;
   row_done_type         row_done;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         obstacle_distance_ff <= OBSTACLE_DISTANCE_RST;
         jump_threshold_ff    <= JUMP_THRESHOLD_RST;
         min_run_length_ff    <= MIN_RUN_LENGTH_RST;
         frame_count_limit_ff <= FRAME_LIMIT_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_OBSTACLE_DISTANCE: obstacle_distance_ff <= csr_write_data;
            CSR_JUMP_THRESHOLD:    jump_threshold_ff    <= csr_write_data;
            CSR_MIN_RUN_LENGTH:    min_run_length_ff    <= csr_write_data[MIN_RUN_W-1:0];
            CSR_FRAME_LIMIT:       frame_count_limit_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // input register handshake
   assign advance   = in_valid_ff && (!in_row_end_ff || can_take);
   assign req.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
      if (req.valid && req.ready) begin
         in_depth_ff   <= req.depth_sample;
         in_row_end_ff <= req.row_end;
      end
   end

   assign seg_cfg.obstacle_distance = obstacle_distance_ff;
   assign seg_cfg.jump_threshold    = jump_threshold_ff;
   assign seg_cfg.min_run_length    = min_run_length_ff;

   dso_run_seg #(
      .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
   ) u_run_seg (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .depth_sample (in_depth_ff),
      .row_end      (in_row_end_ff),
      .cfg          (seg_cfg),
      .row_done     (row_done)
   );

   dso_frame_out u_frame_out (
      .clock             (clock),
      .reset             (reset),
      .row_done          (row_done),
      .frame_count_limit (frame_count_limit_ff),
      .can_take          (can_take),
      .rsp               (rsp)
   );

   // a finished row is never handed over while the response slot is full
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      row_done.valid |-> can_take)
      else $error("row verdict overwrote pending response");

   // a stalled row-end request keeps the input register
   a_row_end_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_row_end_ff && !can_take |=> in_valid_ff && in_row_end_ff)
      else $error("row-end request lost during stall");

   // the input slot is free whenever it was empty or drained
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req.ready)
      else $error("empty input register refused a request");

endmodule

// ----- sv/dso_run_seg.sv -----
// Run segmentation of one scan row: run sum, length, jump test and near-run test.
// Depends on dso_pkg.
module dso_run_seg #(
   parameter int MAX_ROW_PIXELS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic [dso_pkg::DEPTH_W-1:0]         depth_sample,
   input  logic                                row_end,
   input  dso_pkg::seg_cfg_type                cfg,
   output dso_pkg::row_done_type               row_done
);
   import dso_pkg::*;

   localparam int LEN_W  = $clog2(MAX_ROW_PIXELS + 1);
   localparam int SUM_W  = DEPTH_W + LEN_W;
   localparam int CMP_W  = (LEN_W > MIN_RUN_W) ? LEN_W : MIN_RUN_W;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_ROW_PIXELS);

   logic [SUM_W-1:0]   run_sum_ff, run_sum_in;
   logic [LEN_W-1:0]   run_length_ff, run_length_in;
   logic [DEPTH_W-1:0] previous_depth_ff, previous_depth_in;
   logic               frame_hit_ff, frame_hit_in;

   logic [DEPTH_W-1:0] diff;
   logic               is_zero, run_open, is_jump, close_now, add_pixel, grow;
   logic [SUM_W-1:0]   bound_old, bound_new, sum_new;
   logic [LEN_W-1:0]   len_new;
   logic               near_old, near_new, eval_hit, hit_total;

   // pixel classification
   always_comb begin
      diff = (depth_sample > previous_depth_ff) ? depth_sample - previous_depth_ff
                                                : previous_depth_ff - depth_sample;
      is_zero   = (depth_sample == '0);
      run_open  = (run_length_ff != '0);
      is_jump   = run_open && !is_zero && (diff >= cfg.jump_threshold);
      close_now = run_open && (is_zero || is_jump);
      add_pixel = !is_zero && !is_jump;
      grow      = add_pixel && (run_length_ff < LEN_MAX);
   end

   // mean test as sum < distance * length, on the run before and after this pixel
   always_comb begin
      bound_old = SUM_W'(cfg.obstacle_distance) * SUM_W'(run_length_ff);
      bound_new = bound_old + (grow ? SUM_W'(cfg.obstacle_distance) : '0);
      sum_new   = run_sum_ff + (grow ? SUM_W'(depth_sample) : '0);
      len_new   = run_length_ff + (grow ? LEN_W'(1) : '0);
      near_old  = (CMP_W'(run_length_ff) > CMP_W'(cfg.min_run_length)) &&
                  (run_sum_ff < bound_old);
      near_new  = (CMP_W'(len_new) > CMP_W'(cfg.min_run_length)) &&
                  (sum_new < bound_new);
      if (close_now) begin
         eval_hit = near_old;
      end else begin
         eval_hit = row_end && near_new;
      end
      hit_total = frame_hit_ff || eval_hit;
   end

   // next run state
   always_comb begin
      run_sum_in        = run_sum_ff;
      run_length_in     = run_length_ff;
      previous_depth_in = previous_depth_ff;
      frame_hit_in      = frame_hit_ff;
      if (advance) begin
         if (add_pixel) begin
            previous_depth_in = depth_sample;
         end
         if (row_end) begin
            run_sum_in    = '0;
            run_length_in = '0;
            frame_hit_in  = 1'b0;
         end else if (close_now) begin
            run_sum_in    = '0;
            run_length_in = '0;
            frame_hit_in  = hit_total;
         end else begin
            run_sum_in    = sum_new;
            run_length_in = len_new;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         run_sum_ff        <= '0;
         run_length_ff     <= '0;
         previous_depth_ff <= '0;
         frame_hit_ff      <= 1'b0;
      end else begin
         run_sum_ff        <= run_sum_in;
         run_length_ff     <= run_length_in;
         previous_depth_ff <= previous_depth_in;
         frame_hit_ff      <= frame_hit_in;
      end
   end

   assign row_done.valid = advance && row_end;
   assign row_done.hit   = hit_total;

   // run length never passes the row limit
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      run_length_ff <= LEN_MAX)
      else $error("run length above row limit");

   // an empty run carries no sum
   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      run_length_ff == '0 |-> run_sum_ff == '0)
      else $error("empty run with nonzero sum");

   // row end leaves a clean row state
   a_row_clear: assert property (@(posedge clock) disable iff (reset)
      row_done.valid |=> (run_length_ff == '0) && !frame_hit_ff)
      else $error("row state not cleared at row end");

endmodule

// ----- sv/dso_frame_out.sv -----
// Consecutive marked frame counter and response output register.
// Depends on dso_pkg and dso_rsp_if.
module dso_frame_out (
   input  logic                        clock,
   input  logic                        reset,
   input  dso_pkg::row_done_type       row_done,
   input  logic [dso_pkg::COUNT_W-1:0] frame_count_limit,
   output logic                        can_take,
   dso_rsp_if.source                   rsp
);
   import dso_pkg::*;

   logic               valid_ff, valid_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               alarm_ff, alarm_in;
   logic               marked_ff, marked_in;

   assign can_take = !valid_ff || rsp.ready;

   // saturating count and alarm for the finished row
   always_comb begin
      count_in  = count_ff;
      alarm_in  = alarm_ff;
      marked_in = marked_ff;
      valid_in  = valid_ff && !rsp.ready;
      if (row_done.valid) begin
         if (row_done.hit) begin
            count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_W'(1);
         end else begin
            count_in = '0;
         end
         alarm_in  = (count_in > frame_count_limit);
         marked_in = row_done.hit;
         valid_in  = 1'b1;
      end
   end

   // counter and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
      alarm_ff  <= alarm_in;
      marked_ff <= marked_in;
   end

   assign rsp.valid              = valid_ff;
   assign rsp.obstacle_alarm     = alarm_ff;
   assign rsp.frame_marked       = marked_ff;
   assign rsp.consecutive_frames = count_ff;

   // alarm agrees with the count it reports
   a_alarm_count: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (alarm_ff == (count_ff > frame_count_limit)))
      else $error("alarm disagrees with count");

   // an unmarked frame resets the count
   a_unmarked_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !marked_ff |-> count_ff == '0)
      else $error("count not cleared on unmarked frame");

   // a marked frame always leaves a nonzero count
   a_marked_count: assert property (@(posedge clock) disable iff (reset)
      valid_ff && marked_ff |-> count_ff != '0)
      else $error("marked frame with zero count");

endmodule
